// ===== rtl/core/dlre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlre_pkg
// Shared types and constants of the display lookup table range editor.
// ----------------------------------------------------------------------------
package dlre_pkg;

	localparam int DEF_INDEX_BITS = 8;
	localparam int DEF_VALUE_BITS = 8;

	localparam int FIELD_W = 8;
	localparam int OP_W    = 3;
	localparam int ST_W    = 2;
	localparam int CFG_W   = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE   = 3'd0,
		OP_READ    = 3'd1,
		OP_FILL    = 3'd2,
		OP_RAMP    = 3'd3,
		OP_RESTORE = 3'd4,
		OP_CAPTURE = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2
	} stat_code_t;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [FIELD_W-1:0] first_index;
		logic [FIELD_W-1:0] last_index;
		logic [FIELD_W-1:0] first_value;
		logic [FIELD_W-1:0] last_value;
	} cmd_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] read_value;
		logic [ST_W-1:0]    status;
	} rsp_item_t;

	typedef struct packed {
		logic load;
		logic clear_wr;
		logic wr_single;
		logic rd;
		logic fill_wr;
		logic div_start;
		logic ramp_init;
		logic ramp_wr;
		logic copy_rd;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic            skip;
		logic [OP_W-1:0] op;
		logic            idx_last;
		logic            clr_last;
		logic            div_done;
	} dp_stat_t;

endpackage

// ===== rtl/core/dlre_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlre_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface dlre_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ===== rtl/core/display_lut_range_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_lut_range_editor
// Display lookup table with a saved default copy, edited by range commands.
//
// cmd carries one command per transfer, rsp returns one result per command,
// cfg writes the active index width at any transfer (always ready).
// Commands are handled one at a time; a new command is taken while the
// previous result still waits on rsp.
// Each command is loaded and checked; a write or read then makes its single
// access, a rejected or empty command goes straight to the result, a flat fill
// writes each entry in turn, a linear ramp first runs the 8-step divider and
// then writes each entry, and restore and capture read then write per entry.
// Capture walks the whole active table, up to 2^INDEX_BITS entries.
// After reset both stores are cleared one entry per cycle, all 2^INDEX_BITS
// entries, during which cmd.ready stays low; cfg is taken meanwhile.
// A stalled rsp holds its result; the next command then completes its work
// and waits before loading the result register.
// ----------------------------------------------------------------------------
module display_lut_range_editor #(
	parameter int INDEX_BITS = dlre_pkg::DEF_INDEX_BITS,
	parameter int VALUE_BITS = dlre_pkg::DEF_VALUE_BITS
) (
	input logic        clk,
	input logic        arst_n,
	dlre_chan_if.sink   cmd,
	dlre_chan_if.source rsp,
	dlre_chan_if.sink   cfg
);
	import dlre_pkg::*;

	ctrl_cmd_t ctl_cmd;
	dp_stat_t  dp_stat;

	assign cfg.ready = 1'b1;

	dlre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (ctl_cmd),
		.stat      (dp_stat)
	);

	dlre_dp #(
		.INDEX_BITS (INDEX_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (cmd.data),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.cmd      (ctl_cmd),
		.stat     (dp_stat),
		.rsp      (rsp.data)
	);

endmodule

// ===== rtl/core/dlre_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlre_div
// Restoring divider, one quotient bit per cycle, for the ramp step size.
// ----------------------------------------------------------------------------
module dlre_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [dlre_pkg::FIELD_W-1:0] dividend,
	input  logic [dlre_pkg::FIELD_W-1:0] divisor,
	output logic                   done,
	output logic [dlre_pkg::FIELD_W-1:0] quotient,
	output logic [dlre_pkg::FIELD_W-1:0] remainder
);
	import dlre_pkg::*;

	localparam int CNT_W = $clog2(FIELD_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FIELD_W-1:0] quo_q;
	logic [FIELD_W-1:0] rem_q;
	logic [FIELD_W:0]   shifted;
	logic               fits;

	assign shifted = {rem_q, quo_q[FIELD_W-1]};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FIELD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? FIELD_W'(shifted - {1'b0, divisor}) : shifted[FIELD_W-1:0];
			quo_q <= {quo_q[FIELD_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/dlre_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlre_dp
// Datapath: table and default stores, range checks, index walk, ramp stepper.
// ----------------------------------------------------------------------------
module dlre_dp #(
	parameter int INDEX_BITS = dlre_pkg::DEF_INDEX_BITS,
	parameter int VALUE_BITS = dlre_pkg::DEF_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dlre_pkg::cmd_item_t              item,
	input  logic                             cfg_we,
	input  logic [dlre_pkg::CFG_W-1:0]       cfg_data,
	input  dlre_pkg::ctrl_cmd_t              cmd,
	output dlre_pkg::dp_stat_t               stat,
	output dlre_pkg::rsp_item_t              rsp
);
	import dlre_pkg::*;

	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int CW    = (INDEX_BITS + 1 > FIELD_W + 1) ? INDEX_BITS + 1 : FIELD_W + 1;
	localparam int VMB   = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
	localparam logic [FIELD_W-1:0] VMASK = FIELD_W'((1 << VMB) - 1);
	localparam int QW    = FIELD_W + 3;

	// configuration
	logic [CFG_W-1:0] aib_q;
	logic [CFG_W-1:0] act_bits;
	logic [CW-1:0]    size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aib_q <= CFG_RESET;
		end else if (cfg_we) begin
			aib_q <= cfg_data;
		end
	end

	always_comb begin
		if (aib_q == '0) begin
			act_bits = CFG_W'(1);
		end else if (aib_q > CFG_W'(INDEX_BITS)) begin
			act_bits = CFG_W'(INDEX_BITS);
		end else begin
			act_bits = aib_q;
		end
	end

	assign size = CW'(1) << act_bits;

	// command decode at load
	logic [FIELD_W-1:0]    lo;
	logic [FIELD_W-1:0]    hi;
	logic                  oob_s;
	logic                  oob_e;
	logic                  oob_hi;
	logic [ST_W-1:0]       ld_st;
	logic                  ld_skip;
	logic [INDEX_BITS-1:0] ld_start;
	logic [INDEX_BITS-1:0] ld_end;

	assign lo     = (item.first_index > item.last_index) ? item.last_index : item.first_index;
	assign hi     = (item.first_index > item.last_index) ? item.first_index : item.last_index;
	assign oob_s  = CW'(item.first_index) >= size;
	assign oob_e  = CW'(item.last_index) >= size;
	assign oob_hi = CW'(hi) >= size;

	always_comb begin
		ld_st    = STAT_DONE;
		ld_skip  = 1'b0;
		ld_start = INDEX_BITS'(item.first_index);
		ld_end   = INDEX_BITS'(item.last_index);
		unique case (item.operation) inside
			OP_WRITE, OP_READ: begin
				if (oob_s) ld_st = STAT_RANGE;
			end
			OP_FILL: begin
				ld_start = INDEX_BITS'(lo);
				ld_end   = INDEX_BITS'(hi);
				if (oob_hi) ld_st = STAT_RANGE;
			end
			OP_RAMP: begin
				if (oob_s || oob_e) begin
					ld_st = STAT_RANGE;
				end else if (item.last_index <= item.first_index) begin
					ld_st = STAT_EMPTY;
				end
			end
			OP_RESTORE: begin
				if (item.first_index > item.last_index) begin
					ld_skip = 1'b1;
				end else if (oob_e) begin
					ld_st = STAT_RANGE;
				end
			end
			OP_CAPTURE: begin
				ld_start = '0;
				ld_end   = INDEX_BITS'(size - CW'(1));
			end
			default: ld_skip = 1'b1;
		endcase
		if (ld_st != STAT_DONE) ld_skip = 1'b1;
	end

	logic [OP_W-1:0]       op_q;
	logic [ST_W-1:0]       st_q;
	logic                  skip_q;
	logic [INDEX_BITS-1:0] end_q;
	logic [FIELD_W-1:0]    sv_q;
	logic [FIELD_W-1:0]    ev_q;
	logic [FIELD_W-1:0]    span_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= item.operation;
			st_q   <= ld_st;
			skip_q <= ld_skip;
			end_q  <= ld_end;
			sv_q   <= item.first_value & VMASK;
			ev_q   <= item.last_value & VMASK;
			span_q <= item.last_index - item.first_index;
		end
	end

	// index walk
	logic [INDEX_BITS-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= ld_start;
		end else if (cmd.clear_wr || cmd.fill_wr || cmd.ramp_wr || cmd.copy_rd) begin
			idx_q <= idx_q + INDEX_BITS'(1);
		end
	end

	// ramp step size
	logic               neg;
	logic [FIELD_W-1:0] mag;
	logic               div_done;
	logic [FIELD_W-1:0] quo;
	logic [FIELD_W-1:0] rem;

	assign neg = ev_q < sv_q;
	assign mag = neg ? (sv_q - ev_q) : (ev_q - sv_q);

	dlre_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (mag),
		.divisor   (span_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	logic signed [QW-1:0] q_q;
	logic signed [QW-1:0] dq_q;
	logic [FIELD_W-1:0]   r_q;
	logic [FIELD_W-1:0]   dr_q;
	logic [FIELD_W:0]     r_sum;
	logic signed [QW-1:0] quo_x;

	assign r_sum = {1'b0, r_q} + {1'b0, dr_q};
	assign quo_x = $signed({3'b000, quo});

	always_ff @(posedge clk) begin
		if (cmd.ramp_init) begin
			q_q <= $signed({3'b000, sv_q});
			r_q <= '0;
			if (neg && rem != '0) begin
				dq_q <= -(quo_x + QW'(1));
				dr_q <= span_q - rem;
			end else if (neg) begin
				dq_q <= -quo_x;
				dr_q <= '0;
			end else begin
				dq_q <= quo_x;
				dr_q <= rem;
			end
		end else if (cmd.ramp_wr) begin
			if (r_sum >= {1'b0, span_q}) begin
				r_q <= FIELD_W'(r_sum - {1'b0, span_q});
				q_q <= q_q + dq_q + QW'(1);
			end else begin
				r_q <= r_sum[FIELD_W-1:0];
				q_q <= q_q + dq_q;
			end
		end
	end

	// stores
	logic [VALUE_BITS-1:0] tbl_mem [DEPTH];
	logic [VALUE_BITS-1:0] dfl_mem [DEPTH];
	logic [VALUE_BITS-1:0] tbl_rdata_q;
	logic [VALUE_BITS-1:0] dfl_rdata_q;

	logic                  cp_s1;
	logic                  cp_restore_s1;
	logic [INDEX_BITS-1:0] idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_s1 <= 1'b0;
		end else begin
			cp_s1 <= cmd.copy_rd;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1        <= idx_q;
		cp_restore_s1 <= (op_q == OP_RESTORE);
	end

	logic                  tbl_we;
	logic [INDEX_BITS-1:0] tbl_wa;
	logic [VALUE_BITS-1:0] tbl_wd;
	logic                  tbl_re;
	logic                  dfl_we;
	logic [INDEX_BITS-1:0] dfl_wa;
	logic [VALUE_BITS-1:0] dfl_wd;
	logic                  dfl_re;

	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = idx_q;
		tbl_wd = '0;
		if (cmd.clear_wr) begin
			tbl_we = 1'b1;
		end else if (cmd.wr_single || cmd.fill_wr) begin
			tbl_we = 1'b1;
			tbl_wd = VALUE_BITS'(sv_q);
		end else if (cmd.ramp_wr) begin
			tbl_we = 1'b1;
			tbl_wd = VALUE_BITS'(q_q[FIELD_W-1:0] & VMASK);
		end else if (cp_s1 && cp_restore_s1) begin
			tbl_we = 1'b1;
			tbl_wa = idx_s1;
			tbl_wd = dfl_rdata_q;
		end
	end

	always_comb begin
		dfl_we = 1'b0;
		dfl_wa = idx_q;
		dfl_wd = '0;
		if (cmd.clear_wr) begin
			dfl_we = 1'b1;
		end else if (cp_s1 && !cp_restore_s1) begin
			dfl_we = 1'b1;
			dfl_wa = idx_s1;
			dfl_wd = tbl_rdata_q;
		end
	end

	assign tbl_re = cmd.rd || (cmd.copy_rd && op_q == OP_CAPTURE);
	assign dfl_re = cmd.copy_rd && op_q == OP_RESTORE;

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
		if (tbl_re) tbl_rdata_q <= tbl_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (dfl_we) dfl_mem[dfl_wa] <= dfl_wd;
		if (dfl_re) dfl_rdata_q <= dfl_mem[idx_q];
	end

	// result register
	rsp_item_t rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.read_value <= (op_q == OP_READ && st_q == STAT_DONE) ?
				FIELD_W'(tbl_rdata_q) : '0;
			rsp_q.status     <= st_q;
		end
	end

	assign rsp = rsp_q;

	assign stat.skip     = skip_q;
	assign stat.op       = op_q;
	assign stat.idx_last = idx_q == end_q;
	assign stat.clr_last = &idx_q;
	assign stat.div_done = div_done;

endmodule

// ===== rtl/core/dlre_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlre_ctrl
// Controller: clearing pass, command sequencing and result handshake.
// ----------------------------------------------------------------------------
module dlre_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output dlre_pkg::ctrl_cmd_t cmd,
	input  dlre_pkg::dp_stat_t  stat
);
	import dlre_pkg::*;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_CHECK = 9'b000000100,
		ST_FILL  = 9'b000001000,
		ST_DIV   = 9'b000010000,
		ST_RAMP  = 9'b000100000,
		ST_COPY  = 9'b001000000,
		ST_DRAIN = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.skip) begin
					state_nx = ST_FIN;
				end else begin
					unique case (stat.op) inside
						OP_WRITE: begin
							cmd.wr_single = 1'b1;
							state_nx      = ST_FIN;
						end
						OP_READ: begin
							cmd.rd   = 1'b1;
							state_nx = ST_FIN;
						end
						OP_FILL: state_nx = ST_FILL;
						OP_RAMP: begin
							cmd.div_start = 1'b1;
							state_nx      = ST_DIV;
						end
						OP_RESTORE, OP_CAPTURE: state_nx = ST_COPY;
						default: state_nx = ST_FIN;
					endcase
				end
			end
			ST_FILL: begin
				cmd.fill_wr = 1'b1;
				if (stat.idx_last) state_nx = ST_FIN;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.ramp_init = 1'b1;
					state_nx      = ST_RAMP;
				end
			end
			ST_RAMP: begin
				cmd.ramp_wr = 1'b1;
				if (stat.idx_last) state_nx = ST_FIN;
			end
			ST_COPY: begin
				cmd.copy_rd = 1'b1;
				if (stat.idx_last) state_nx = ST_DRAIN;
			end
			ST_DRAIN: state_nx = ST_FIN;
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
